// ===== rtl/core/mvn_pkg.sv =====
// Package for the mesh vertex normals block: widths, codes, beat and control types.
// Used by every module under rtl/core except mvn_ram; depends on nothing else.
`default_nettype none

package mvn_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int LANES        = 3;

	localparam int IDX_W  = 10;
	localparam int POS_W  = 24;
	localparam int EDGE_W = POS_W + 1;
	localparam int PROD_W = 2 * EDGE_W;
	localparam int N_W    = PROD_W + 1;
	localparam int SUM_W  = 64;
	localparam int MAG_W  = 30;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int L2_W   = SQ_W + 2;
	localparam int LEN_W  = 31;
	localparam int FRAC_W = 15;
	localparam int NUM_W  = MAG_W + FRAC_W + 1;
	localparam int UNIT_W = 16;
	localparam int STEP_W = 5;
	localparam int DCNT_W = 6;

	localparam int ROOT_STEPS = L2_W / 2;
	localparam int DIV_STEPS  = NUM_W;
	localparam int UNIT_MAX   = 32767;

	typedef enum logic [1:0] {
		KIND_VERTEX   = 2'd0,
		KIND_TRIANGLE = 2'd1,
		KIND_READ     = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TRI_RD,
		ST_TRI_CROSS,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_RD_SUM,
		ST_RD_MAG,
		ST_RD_SHIFT,
		ST_RD_SQ,
		ST_RD_L2,
		ST_RD_CHK,
		ST_RD_ROOT,
		ST_RD_DIVGO,
		ST_RD_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [IDX_W-1:0]        vertex_index;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [IDX_W-1:0]        corner_a;
		logic [IDX_W-1:0]        corner_b;
		logic [IDX_W-1:0]        corner_c;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         read_index;
		logic signed [UNIT_W-1:0] unit_x;
		logic signed [UNIT_W-1:0] unit_y;
		logic signed [UNIT_W-1:0] unit_z;
		logic                     zero_length;
	} result_t;

	typedef struct packed {
		logic             vtx_we;
		logic             sum_we;
		logic             sum_clr;
		logic [IDX_W-1:0] addr;
		logic             mag_ld;
		logic             shr;
		logic             div_start;
	} lane_ctl_t;

	typedef struct packed {
		logic big;
		logic done;
	} lane_sts_t;

	typedef struct packed {
		logic cap_a;
		logic cap_b;
		logic cap_c;
	} cross_ctl_t;

	typedef struct packed {
		logic ld;
		logic step;
	} root_ctl_t;

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		in_range = (32'(idx) < MAX_VERTICES);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mvn_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module mvn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/mvn_lane.sv =====
// One coordinate lane: position and accumulator memories, saturating accumulate,
// magnitude scaling, square and restoring divider. Depends on mvn_pkg and mvn_ram.
`default_nettype none

module mvn_lane (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mvn_pkg::lane_ctl_t                ctl,
	input  wire logic signed [mvn_pkg::POS_W-1:0]  pos,
	input  wire logic signed [mvn_pkg::N_W-1:0]    n_comp,
	input  wire logic [mvn_pkg::LEN_W-1:0]         len,
	output logic signed [mvn_pkg::POS_W-1:0]       vtx,
	output logic [mvn_pkg::SQ_W-1:0]               sq,
	output logic signed [mvn_pkg::UNIT_W-1:0]      unit,
	output mvn_pkg::lane_sts_t                     sts
);
	import mvn_pkg::*;

	logic [POS_W-1:0]  vtx_raw;
	logic [SUM_W-1:0]  sum_rd;
	logic [SUM_W-1:0]  sum_wd;
	logic [SUM_W:0]    acc_wide;
	logic [SUM_W-1:0]  acc_sat;
	logic [SUM_W-1:0]  mag_q;
	logic              neg_q;
	logic [SQ_W-1:0]   sq_q;
	logic [NUM_W-1:0]  num_q;
	logic [LEN_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic [LEN_W:0]    trial;
	logic [LEN_W:0]    trial_diff;
	logic              trial_ge;
	logic [UNIT_W-2:0] q_sat;

	mvn_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_vtx_ram (
		.clk   (clk),
		.we    (ctl.vtx_we),
		.waddr (ctl.addr),
		.wdata (pos),
		.raddr (ctl.addr),
		.rdata (vtx_raw)
	);

	mvn_ram #(.WIDTH(SUM_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
		.clk   (clk),
		.we    (ctl.sum_we),
		.waddr (ctl.addr),
		.wdata (sum_wd),
		.raddr (ctl.addr),
		.rdata (sum_rd)
	);

	assign vtx = signed'(vtx_raw);

	// saturate to the signed 64-bit range on overflow
	always_comb begin
		acc_wide = {sum_rd[SUM_W-1], sum_rd} + (SUM_W+1)'(n_comp);
		if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
			acc_sat = acc_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			acc_sat = acc_wide[SUM_W-1:0];
		end
		sum_wd = ctl.sum_clr ? '0 : acc_sat;
	end

	always_ff @(posedge clk) begin
		if (ctl.mag_ld) begin
			neg_q <= sum_rd[SUM_W-1];
			mag_q <= sum_rd[SUM_W-1] ? (SUM_W'(0) - sum_rd) : sum_rd;
		end else if (ctl.shr) begin
			mag_q <= mag_q >> 1;
		end
		sq_q <= mag_q[MAG_W-1:0] * mag_q[MAG_W-1:0];
	end

	assign sq = sq_q;

	always_comb begin
		trial      = {rem_q, num_q[NUM_W-1]};
		trial_ge   = (trial >= {1'b0, len});
		trial_diff = trial - {1'b0, len};
	end

	// restoring divide, one quotient bit a cycle; quotient shifts into num_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.div_start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			num_q <= {mag_q[MAG_W-1:0], {FRAC_W{1'b0}}} + NUM_W'(len >> 1);
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_diff[LEN_W-1:0] : trial[LEN_W-1:0];
		end
	end

	assign q_sat = (|num_q[NUM_W-1:UNIT_W-1]) ? (UNIT_W-1)'(UNIT_MAX) : num_q[UNIT_W-2:0];
	assign unit  = neg_q ? -signed'({1'b0, q_sat}) : signed'({1'b0, q_sat});

	assign sts.big  = |mag_q[SUM_W-1:MAG_W];
	assign sts.done = ~busy_q;

endmodule

`default_nettype wire

// ===== rtl/core/mvn_cross.sv =====
// Merge stage for triangles: captures the three corners, forms edges and the
// cross product -(e01 x e02) over three registered stages. Depends on mvn_pkg.
`default_nettype none

module mvn_cross (
	input  wire logic                              clk,
	input  wire mvn_pkg::cross_ctl_t               ctl,
	input  wire logic signed [mvn_pkg::POS_W-1:0]  vtx [mvn_pkg::LANES],
	output logic signed [mvn_pkg::N_W-1:0]         n [mvn_pkg::LANES]
);
	import mvn_pkg::*;

	logic signed [POS_W-1:0]  pa_q [LANES];
	logic signed [POS_W-1:0]  pb_q [LANES];
	logic signed [POS_W-1:0]  pc_q [LANES];
	logic signed [EDGE_W-1:0] u_s1 [LANES];
	logic signed [EDGE_W-1:0] v_s1 [LANES];
	logic signed [PROD_W-1:0] p_s2 [6];
	logic signed [N_W-1:0]    n_s3 [LANES];

	always_ff @(posedge clk) begin
		for (int j = 0; j < LANES; j++) begin
			if (ctl.cap_a) pa_q[j] <= vtx[j];
			if (ctl.cap_b) pb_q[j] <= vtx[j];
			if (ctl.cap_c) pc_q[j] <= vtx[j];
			u_s1[j] <= EDGE_W'(pb_q[j]) - EDGE_W'(pa_q[j]);
			v_s1[j] <= EDGE_W'(pc_q[j]) - EDGE_W'(pa_q[j]);
		end
		p_s2[0] <= PROD_W'(v_s1[1]) * PROD_W'(u_s1[2]);
		p_s2[1] <= PROD_W'(v_s1[2]) * PROD_W'(u_s1[1]);
		p_s2[2] <= PROD_W'(v_s1[2]) * PROD_W'(u_s1[0]);
		p_s2[3] <= PROD_W'(v_s1[0]) * PROD_W'(u_s1[2]);
		p_s2[4] <= PROD_W'(v_s1[0]) * PROD_W'(u_s1[1]);
		p_s2[5] <= PROD_W'(v_s1[1]) * PROD_W'(u_s1[0]);
		for (int j = 0; j < LANES; j++) begin
			n_s3[j] <= N_W'(p_s2[2*j]) - N_W'(p_s2[2*j+1]);
		end
	end

	assign n = n_s3;

endmodule

`default_nettype wire

// ===== rtl/core/mvn_root.sv =====
// Merge stage for reads: sums the lane squares and takes the integer square root,
// one result bit a cycle. Depends on mvn_pkg.
`default_nettype none

module mvn_root (
	input  wire logic                          clk,
	input  wire mvn_pkg::root_ctl_t            ctl,
	input  wire logic [mvn_pkg::SQ_W-1:0]      sq [mvn_pkg::LANES],
	output logic [mvn_pkg::LEN_W-1:0]          len,
	output logic                               zero
);
	import mvn_pkg::*;

	logic [L2_W-1:0] x_q;
	logic [L2_W-1:0] res_q;
	logic [L2_W-1:0] bit_q;
	logic [L2_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk) begin
		if (ctl.ld) begin
			x_q   <= L2_W'(sq[0]) + L2_W'(sq[1]) + L2_W'(sq[2]);
			res_q <= '0;
			bit_q <= L2_W'(1) << (L2_W - 2);
		end else if (ctl.step) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign len  = res_q[LEN_W-1:0];
	assign zero = (x_q == '0);

endmodule

`default_nettype wire

// ===== rtl/core/mesh_vertex_normals.sv =====
// Top level of the mesh vertex normals block: sequencer, three coordinate lanes,
// cross-product and square-root merge stages, result register. Depends on mvn_pkg, mvn_lane, mvn_cross and mvn_root.
`default_nettype none

// Area-weighted vertex normals. Three item kinds arrive on the item channel:
// a vertex write stores a Q12.12 position and zeroes that vertex's accumulator;
// a triangle reads its three corners, forms n = -(e01 x e02) and adds it with
// signed 64-bit saturation to each corner's accumulator (four vertex-memory
// read slots, three cross-product stages, then a read and a write of the
// accumulator memory for each corner in turn, which is what keeps repeated
// corners exact); a read returns the accumulated normal as a unit vector in
// signed Q1.15 on the result channel (up to 34 one-bit scaling shifts, 31
// square-root steps and a 46-step divide running in all three lanes at once).
// Out-of-range reads and zero sums return a zero vector with zero_length set;
// kind 3 and out-of-range writes or triangles are dropped. Each coordinate lives
// in its own lane with its own position and accumulator memories. After reset
// the block sweeps zeros through all MAX_VERTICES (1024) accumulator entries
// and holds item_stall high meanwhile. One item is worked on at a time; a
// finished result waits in an output register, so the next item is taken while
// that beat is still stalled.
module mesh_vertex_normals (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire mvn_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output mvn_pkg::result_t      result
);
	import mvn_pkg::*;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [IDX_W-1:0]  clr_q, clr_d;
	item_t             item_q;
	logic              zero_q, zero_d;
	logic              res_valid_q;
	result_t           result_q;
	logic              load_res;
	logic              accept;

	lane_ctl_t         lctl;
	cross_ctl_t        cctl;
	root_ctl_t         rctl;
	lane_sts_t         sts   [LANES];
	logic signed [POS_W-1:0]  pos_in [LANES];
	logic signed [POS_W-1:0]  vtx    [LANES];
	logic signed [N_W-1:0]    n_comp [LANES];
	logic [SQ_W-1:0]          sq     [LANES];
	logic signed [UNIT_W-1:0] unit   [LANES];
	logic [LEN_W-1:0]         len;
	logic                     root_zero;
	logic                     any_big;
	logic                     all_done;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid & ~item_stall;

	assign pos_in[0] = item.pos_x;
	assign pos_in[1] = item.pos_y;
	assign pos_in[2] = item.pos_z;

	// one lane per coordinate
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		mvn_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lctl),
			.pos    (pos_in[g]),
			.n_comp (n_comp[g]),
			.len    (len),
			.vtx    (vtx[g]),
			.sq     (sq[g]),
			.unit   (unit[g]),
			.sts    (sts[g])
		);
	end

	mvn_cross u_cross (
		.clk (clk),
		.ctl (cctl),
		.vtx (vtx),
		.n   (n_comp)
	);

	mvn_root u_root (
		.clk  (clk),
		.ctl  (rctl),
		.sq   (sq),
		.len  (len),
		.zero (root_zero)
	);

	assign any_big  = sts[0].big | sts[1].big | sts[2].big;
	assign all_done = sts[0].done & sts[1].done & sts[2].done;

	function automatic logic [IDX_W-1:0] corner(input item_t it, input logic [STEP_W-1:0] s);
		logic [IDX_W-1:0] c;
		case (s)
			STEP_W'(0): c = it.corner_a;
			STEP_W'(1): c = it.corner_b;
			default:    c = it.corner_c;
		endcase
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			step_q      <= '0;
			clr_q       <= '0;
			zero_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			clr_q   <= clr_d;
			zero_q  <= zero_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// hold the item and the result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (load_res) begin
			result_q.read_index  <= item_q.vertex_index;
			result_q.unit_x      <= zero_q ? '0 : unit[0];
			result_q.unit_y      <= zero_q ? '0 : unit[1];
			result_q.unit_z      <= zero_q ? '0 : unit[2];
			result_q.zero_length <= zero_q;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		clr_d    = clr_q;
		zero_d   = zero_q;
		load_res = 1'b0;
		lctl     = '0;
		cctl     = '0;
		rctl     = '0;
		case (state_q)
			ST_CLEAR: begin
				// sweep zeros through every accumulator entry
				lctl.sum_we  = 1'b1;
				lctl.sum_clr = 1'b1;
				lctl.addr    = clr_q;
				clr_d        = clr_q + 1'b1;
				if (clr_q == IDX_W'(MAX_VERTICES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				lctl.addr = item.vertex_index;
				if (accept) begin
					case (kind_t'(item.kind))
						KIND_VERTEX: begin
							if (in_range(item.vertex_index)) begin
								lctl.vtx_we  = 1'b1;
								lctl.sum_we  = 1'b1;
								lctl.sum_clr = 1'b1;
							end
						end
						KIND_TRIANGLE: begin
							if (in_range(item.corner_a) && in_range(item.corner_b) &&
								in_range(item.corner_c)) begin
								state_d = ST_TRI_RD;
								step_d  = '0;
							end
						end
						KIND_READ: begin
							zero_d  = 1'b1;
							state_d = in_range(item.vertex_index) ? ST_RD_SUM : ST_OUT;
						end
						default: begin
						end
					endcase
				end
			end
			ST_TRI_RD: begin
				// read a, b, c; each arrives in the cycle after its address
				lctl.addr  = corner(item_q, step_q);
				cctl.cap_a = (step_q == STEP_W'(1));
				cctl.cap_b = (step_q == STEP_W'(2));
				cctl.cap_c = (step_q == STEP_W'(3));
				step_d     = step_q + 1'b1;
				if (step_q == STEP_W'(3)) begin
					state_d = ST_TRI_CROSS;
					step_d  = '0;
				end
			end
			ST_TRI_CROSS: begin
				step_d = step_q + 1'b1;
				if (step_q == STEP_W'(2)) begin
					state_d = ST_ACC_RD;
					step_d  = '0;
				end
			end
			ST_ACC_RD: begin
				lctl.addr = corner(item_q, step_q);
				state_d   = ST_ACC_WR;
			end
			ST_ACC_WR: begin
				lctl.addr   = corner(item_q, step_q);
				lctl.sum_we = 1'b1;
				if (step_q == STEP_W'(2)) begin
					state_d = ST_IDLE;
					step_d  = '0;
				end else begin
					state_d = ST_ACC_RD;
					step_d  = step_q + 1'b1;
				end
			end
			ST_RD_SUM: begin
				lctl.addr = item_q.vertex_index;
				state_d   = ST_RD_MAG;
			end
			ST_RD_MAG: begin
				lctl.addr   = item_q.vertex_index;
				lctl.mag_ld = 1'b1;
				state_d     = ST_RD_SHIFT;
			end
			ST_RD_SHIFT: begin
				// shift all three magnitudes until the largest fits 30 bits
				if (any_big) begin
					lctl.shr = 1'b1;
				end else begin
					state_d = ST_RD_SQ;
				end
			end
			ST_RD_SQ: begin
				state_d = ST_RD_L2;
			end
			ST_RD_L2: begin
				rctl.ld = 1'b1;
				state_d = ST_RD_CHK;
			end
			ST_RD_CHK: begin
				zero_d = root_zero;
				step_d = '0;
				state_d = root_zero ? ST_OUT : ST_RD_ROOT;
			end
			ST_RD_ROOT: begin
				rctl.step = 1'b1;
				step_d    = step_q + 1'b1;
				if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
					state_d = ST_RD_DIVGO;
					step_d  = '0;
				end
			end
			ST_RD_DIVGO: begin
				lctl.div_start = 1'b1;
				state_d        = ST_RD_DIV;
			end
			ST_RD_DIV: begin
				if (all_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// drop the beat into the output register once it is free
				if (!res_valid_q || !result_stall) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

	// non-read items (writes, triangles, kind 3) never raise a result beat right behind them
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.kind != KIND_READ) |=> !$rose(result_valid))
	else $error("result beat raised after a non-read item");

	// a zero-length beat carries a zero vector
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.zero_length) |->
		(result.unit_x == '0 && result.unit_y == '0 && result.unit_z == '0))
	else $error("zero-length beat with nonzero vector");

	// the lane dividers start together and must finish together
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_DIV) |->
		(sts[0].done == sts[1].done && sts[1].done == sts[2].done))
	else $error("lane dividers out of step");

	// no beat leaves the result register during the clearing sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !result_valid)
	else $error("result beat during accumulator clear");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking bench for mesh_vertex_normals: drives vertex, triangle, read and kind 3 beats,
// predicts unit normals internally and compares every result beat. Depends on mvn_pkg.
`timescale 1ns / 100ps

module tb_top;
	import mvn_pkg::*;

	// Predicts unit normals from the area-weighted sums and holds pending results.
	class normal_scoreboard;
		longint pos_mem[3*MAX_VERTICES];
		longint sum_mem[3*MAX_VERTICES];
		result_t pending[$];
		int errors;

		function void clear_state();
			foreach (pos_mem[i]) begin
				pos_mem[i] = 0;
				sum_mem[i] = 0;
			end
			pending.delete();
			errors = 0;
		endfunction

		function longint sat_sum(longint a, longint b);
			longint s;
			s = a + b;
			if (b > 0 && s < a) return 64'sh7FFF_FFFF_FFFF_FFFF;
			if (b < 0 && s > a) return 64'sh8000_0000_0000_0000;
			return s;
		endfunction

		function longint unsigned root_floor(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void note_item(item_t it);
			int a, b, c, v;
			longint u[3], w[3], n[3];
			longint unsigned m[3], mx, l2, len, q;
			int k;
			result_t r;
			v = it.vertex_index;
			case (kind_t'(it.kind))
				KIND_VERTEX: begin
					pos_mem[3*v]   = it.pos_x;
					pos_mem[3*v+1] = it.pos_y;
					pos_mem[3*v+2] = it.pos_z;
					for (int j = 0; j < 3; j++) sum_mem[3*v+j] = 0;
				end
				KIND_TRIANGLE: begin
					a = it.corner_a;
					b = it.corner_b;
					c = it.corner_c;
					for (int j = 0; j < 3; j++) begin
						u[j] = pos_mem[3*b+j] - pos_mem[3*a+j];
						w[j] = pos_mem[3*c+j] - pos_mem[3*a+j];
					end
					n[0] = w[1]*u[2] - w[2]*u[1];
					n[1] = w[2]*u[0] - w[0]*u[2];
					n[2] = w[0]*u[1] - w[1]*u[0];
					// hit each listed corner, so a repeated corner adds twice
					for (int j = 0; j < 3; j++) begin
						sum_mem[3*a+j] = sat_sum(sum_mem[3*a+j], n[j]);
						sum_mem[3*b+j] = sat_sum(sum_mem[3*b+j], n[j]);
						sum_mem[3*c+j] = sat_sum(sum_mem[3*c+j], n[j]);
					end
				end
				KIND_READ: begin
					r = '0;
					r.read_index = it.vertex_index;
					r.zero_length = 1'b1;
					mx = 0;
					l2 = 0;
					k = 0;
					for (int j = 0; j < 3; j++) begin
						m[j] = sum_mem[3*v+j] < 0 ? -sum_mem[3*v+j] : sum_mem[3*v+j];
						if (m[j] > mx) mx = m[j];
					end
					while ((mx >> k) >= (64'd1 << 30)) k++;
					for (int j = 0; j < 3; j++) begin
						m[j] >>= k;
						l2 += m[j] * m[j];
					end
					if (l2 != 0) begin
						len = root_floor(l2);
						r.zero_length = 1'b0;
						for (int j = 0; j < 3; j++) begin
							q = (m[j] * 32768 + len / 2) / len;
							if (q > UNIT_MAX) q = UNIT_MAX;
							if (sum_mem[3*v+j] < 0) q = -q;
							if (j == 0) r.unit_x = q[15:0];
							if (j == 1) r.unit_y = q[15:0];
							if (j == 2) r.unit_z = q[15:0];
						end
					end
					pending.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing pending: index %0d", got.read_index);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.read_index !== e.read_index) begin
				$error("read_index exp %0d got %0d", e.read_index, got.read_index);
				errors++;
			end
			if (got.unit_x !== e.unit_x) begin
				$error("unit_x exp %0d got %0d", e.unit_x, got.unit_x);
				errors++;
			end
			if (got.unit_y !== e.unit_y) begin
				$error("unit_y exp %0d got %0d", e.unit_y, got.unit_y);
				errors++;
			end
			if (got.unit_z !== e.unit_z) begin
				$error("unit_z exp %0d got %0d", e.unit_z, got.unit_z);
				errors++;
			end
			if (got.zero_length !== e.zero_length) begin
				$error("zero_length exp %0d got %0d", e.zero_length, got.zero_length);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b1;
	result_t result;

	normal_scoreboard sb = new();
	bit written[MAX_VERTICES];

	mesh_vertex_normals dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always #5 clk = ~clk;

	// Sample result beats at the rising edge and score them.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
	end

	// Receiver: draw a stall length per beat, sometimes none at all.
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (w == 0) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b1;
				repeat (w) @(negedge clk);
				result_stall <= 1'b0;
			end
			// hold the ready window until one beat passes
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	// Present one beat, hold it until accepted, then note it. Valid stays high
	// after acceptance; the next call drops it or replaces the beat at once.
	task automatic send_item(item_t it, bit dense);
		int gap;
		gap = dense ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
		@(negedge clk);
	endtask

	function automatic item_t noise_bits();
		item_t it;
		it = {$urandom, $urandom, $urandom, $urandom};
		return it;
	endfunction

	task automatic put_vertex(int v, int x, int y, int z, bit dense);
		item_t it;
		it = noise_bits();
		it.kind = KIND_VERTEX;
		it.vertex_index = v;
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		written[v] = 1'b1;
		send_item(it, dense);
	endtask

	task automatic put_tri(int a, int b, int c, bit dense);
		item_t it;
		it = noise_bits();
		it.kind = KIND_TRIANGLE;
		it.corner_a = a;
		it.corner_b = b;
		it.corner_c = c;
		send_item(it, dense);
	endtask

	task automatic put_read(int v, bit dense);
		item_t it;
		it = noise_bits();
		it.kind = KIND_READ;
		it.vertex_index = v;
		send_item(it, dense);
	endtask

	function automatic int pick_written(int lo, int hi);
		int v;
		do v = $urandom_range(lo, hi); while (!written[v]);
		return v;
	endfunction

	function automatic int rand_pos();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 8388607 : -8388608;
			1: return $signed($urandom_range(0, 8191)) - 4096;
			default: return $signed({$urandom} >> 8) - 8388608;
		endcase
	endfunction

	initial begin
		item_t it;
		int n, a, b, c, lo;
		bit dense;
		sb.clear_state();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, repeated corners, zero sum, kind 3.
		put_read(0, 0);
		put_vertex(0, 0, 0, 0, 0);
		put_vertex(1, 8388607, -8388608, 8388607, 0);
		put_vertex(2, -8388608, 8388607, -8388608, 0);
		put_vertex(1023, 4096, 0, 0, 0);
		put_read(1023, 0);
		put_tri(0, 1, 2, 0);
		put_tri(1023, 1, 1, 0);
		put_tri(0, 0, 0, 0);
		for (int i = 0; i < 6; i++) put_tri(0, 2, 1, 1);
		put_read(0, 0);
		put_read(1, 0);
		put_read(2, 0);
		put_read(1023, 1);
		it = noise_bits();
		it.kind = KIND_NONE;
		send_item(it, 0);
		put_vertex(3, 0, 4096, 0, 0);
		put_vertex(4, 0, 0, 4096, 0);
		put_tri(1023, 3, 4, 0);
		put_read(3, 0);
		put_vertex(1, 0, 0, 0, 0);
		put_read(1, 0);
		item_valid <= 1'b0;

		// Pause the sender until every pending result has drained.
		while (sb.pending.size() != 0) @(posedge clk);
		@(negedge clk);

		// Random: small meshes in random windows, with some noise.
		n = 0;
		while (n < 1050) begin
			lo = $urandom_range(0, 1023 - 16);
			dense = $urandom_range(0, 4) == 0;
			for (int i = 0; i < 4; i++) begin
				put_vertex(lo + $urandom_range(0, 15), rand_pos(), rand_pos(), rand_pos(),
					dense);
				n++;
			end
			repeat ($urandom_range(2, 6)) begin
				case ($urandom_range(0, 9))
					0: begin
						it = noise_bits();
						it.kind = KIND_NONE;
						send_item(it, dense);
					end
					1: put_read($urandom_range(0, 1023), dense);
					2, 3, 4: put_read(pick_written(lo, lo + 15), dense);
					default: begin
						a = pick_written(lo, lo + 15);
						b = pick_written(lo, lo + 15);
						c = pick_written(lo, lo + 15);
						put_tri(a, b, c, dense);
					end
				endcase
				n++;
			end
		end
		item_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: well beyond the slowest legal run.
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
